// File: rtl/positional_insert_erase_array_defines.svh
// ============================================================================
// Assertion macros for the positional insert/erase array
// Shared property wrappers, clocked on i_clk, used by the RTL modules.
// ============================================================================
`ifndef POSITIONAL_INSERT_ERASE_ARRAY_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_ARRAY_DEFINES_SVH

// Checked only while the block is out of reset.
`define PIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/pie_pkg.sv
// ============================================================================
// pie_pkg
// Types and constants shared by the positional insert/erase array.
// ============================================================================
`default_nettype none

package pie_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int POS_W        = $clog2(MAX_CAPACITY);
    localparam int INDEX_W      = 6;
    localparam int WORD_W       = 32;

    typedef enum logic [2:0] {
        REQ_READ    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_APPEND  = 3'd2,
        REQ_PREPEND = 3'd3,
        REQ_INSERT  = 3'd4,
        REQ_ERASE   = 3'd5,
        REQ_CLEAR   = 3'd6
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ERASE  = 2'd3
    } t_cell_op;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op                   op;
        logic [POS_W-1:0]           pos;
        logic signed [WORD_W-1:0]   value;
    } t_cell_cmd;

    // Outcome of one request as seen by the output stage.
    typedef struct packed {
        logic    rd_ok;
        t_status status;
    } t_ctrl_res;

endpackage

`default_nettype wire

// File: rtl/pie_req_if.sv
// ============================================================================
// pie_req_if
// Request channel: valid/ready handshake carrying one request word.
// ============================================================================
`default_nettype none

interface pie_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [2:0]                             req_type;
    logic [pie_pkg::INDEX_W-1:0]            index;
    logic signed [pie_pkg::WORD_W-1:0]      value;

    modport source (output valid, output req_type, output index, output value, input ready);
    modport sink   (input valid, input req_type, input index, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/pie_rsp_if.sv
// ============================================================================
// pie_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ============================================================================
`default_nettype none

interface pie_rsp_if #(
    parameter int CAPACITY = 64
);
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                                   valid;
    logic                                   ready;
    logic signed [pie_pkg::WORD_W-1:0]      read_value;
    logic [COUNT_W-1:0]                     count;
    logic                                   is_empty;
    logic [1:0]                             status;

    modport source (output valid, output read_value, output count, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input read_value, input count, input is_empty,
                    input status, output ready);
endinterface

`default_nettype wire

// File: rtl/positional_insert_erase_array.sv
// ============================================================================
// positional_insert_erase_array
// Ordered list of signed 32-bit words held in a row of shifting cells.
// ============================================================================
//
//   Channel  | Direction | Word carried
//   ---------+-----------+-------------------------------------------------
//   i_req    | in        | req_type, index, value
//   o_rsp    | out       | read_value, count, is_empty, status
//
// One request is taken per cycle while the output register is free or drains,
// and its result word appears in the output register on the next cycle. Every
// cell decides its next word from its two neighbors and the broadcast command,
// so an insert or erase moves the whole row at once, whatever its position.
// The read path is one selection across the row. Reset clears the word count
// and the output valid flag; cell contents are not cleared. While a result
// word waits to be taken, no new request is accepted.
//
`default_nettype none

`include "positional_insert_erase_array_defines.svh"

module positional_insert_erase_array #(
    parameter int CAPACITY = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pie_req_if.sink     i_req,
    pie_rsp_if.source   o_rsp
);
    import pie_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic                       accept;
    t_cell_cmd                  cmd;
    t_ctrl_res                  res;
    logic [CW-1:0]              next_count;
    logic signed [WORD_W-1:0]   w_word [CAPACITY];
    logic [AW-1:0]              rd_addr;

    // Output register: holds one result word until the sink takes it.
    logic                       r_rsp_valid;
    logic signed [WORD_W-1:0]   r_rsp_read_value;
    logic [CW-1:0]              r_rsp_count;
    logic                       r_rsp_empty;
    t_status                    r_rsp_status;

    // A new request may enter when the output register is free or drains now.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    pie_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req.req_type),
        .i_index    (i_req.index),
        .i_value    (i_req.value),
        .o_cmd      (cmd),
        .o_res      (res),
        .o_count    (next_count)
    );

    // The row of cells. The bottom cell never takes from below and the top
    // cell keeps its own word on an erase.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [WORD_W-1:0] left;
        logic signed [WORD_W-1:0] right;

        if (k == 0) begin : g_first
            assign left = cmd.value;
        end else begin : g_mid_l
            assign left = w_word[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right = w_word[k];
        end else begin : g_mid_r
            assign right = w_word[k+1];
        end

        pie_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left),
            .i_right (right),
            .o_word  (w_word[k])
        );
    end

    // For a read in range the control passes the index through as the position.
    assign rd_addr = cmd.pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp_read_value <= res.rd_ok ? w_word[rd_addr] : '0;
            r_rsp_count      <= next_count;
            r_rsp_empty      <= (next_count == '0);
            r_rsp_status     <= res.status;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_rsp_read_value;
    assign o_rsp.count      = r_rsp_count;
    assign o_rsp.is_empty   = r_rsp_empty;
    assign o_rsp.status     = r_rsp_status;

    `PIE_ASSERT(a_rsp_follows, accept |=> r_rsp_valid, "accepted request gave no result")
    `PIE_ASSERT(a_empty_match, r_rsp_valid |-> (r_rsp_empty == (r_rsp_count == '0)),
                "empty flag disagrees with count")
    `PIE_ASSERT(a_read_zero, r_rsp_valid && (r_rsp_read_value != '0) |-> (r_rsp_status == ST_OK),
                "nonzero read data on a failed request")

endmodule

`default_nettype wire

// File: rtl/pie_cell.sv
// ============================================================================
// pie_cell
// One storage cell of the list: holds a word and shifts with its neighbors.
// ============================================================================
`default_nettype none

module pie_cell #(
    parameter int K = 0
) (
    input  wire logic                               i_clk,
    input  wire pie_pkg::t_cell_cmd                 i_cmd,
    input  wire logic signed [pie_pkg::WORD_W-1:0]  i_left,
    input  wire logic signed [pie_pkg::WORD_W-1:0]  i_right,
    output logic signed [pie_pkg::WORD_W-1:0]       o_word
);
    import pie_pkg::*;

    localparam logic [POS_W-1:0] K_POS = POS_W'(K);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            CELL_WRITE: begin
                if (i_cmd.pos == K_POS) n_word = i_cmd.value;
            end
            CELL_INSERT: begin
                // Cells above the gap take the word below them.
                if (i_cmd.pos == K_POS) n_word = i_cmd.value;
                else if (K_POS > i_cmd.pos) n_word = i_left;
            end
            CELL_ERASE: begin
                if (K_POS >= i_cmd.pos) n_word = i_right;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// File: rtl/pie_ctrl.sv
// ============================================================================
// pie_ctrl
// Request decode, range and capacity checks, and the word count register.
// ============================================================================
`default_nettype none

`include "positional_insert_erase_array_defines.svh"

module pie_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire logic [2:0]                         i_req_type,
    input  wire logic [pie_pkg::INDEX_W-1:0]        i_index,
    input  wire logic signed [pie_pkg::WORD_W-1:0]  i_value,
    output pie_pkg::t_cell_cmd                      o_cmd,
    output pie_pkg::t_ctrl_res                      o_res,
    output logic [$clog2(CAPACITY+1)-1:0]           o_count
);
    import pie_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             idx_lt;
    logic             idx_le;
    t_cell_op         op;
    logic [CMP_W-1:0] pos;
    t_status          status;
    logic             rd_ok;

    assign idx_ext = CMP_W'(i_index);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = (r_count == CAP_CNT);
    assign idx_lt  = (idx_ext < cnt_ext);
    assign idx_le  = (idx_ext <= cnt_ext);

    always_comb begin
        n_count = r_count;
        op      = CELL_HOLD;
        pos     = idx_ext;
        status  = ST_OK;
        rd_ok   = 1'b0;
        case (t_req_type'(i_req_type))
            REQ_READ: begin
                if (idx_lt) rd_ok = 1'b1;
                else        status = ST_RANGE;
            end
            REQ_WRITE: begin
                if (idx_lt) op = CELL_WRITE;
                else        status = ST_RANGE;
            end
            REQ_APPEND: begin
                pos = cnt_ext;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_PREPEND: begin
                pos = '0;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_INSERT: begin
                // A bad index wins over a full list.
                if (!idx_le) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_ERASE: begin
                if (idx_lt) begin
                    op      = CELL_ERASE;
                    n_count = r_count - CW'(1);
                end else begin
                    status = ST_RANGE;
                end
            end
            REQ_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_cmd.op    = i_accept ? op : CELL_HOLD;
    assign o_cmd.pos   = POS_W'(pos);
    assign o_cmd.value = i_value;
    assign o_res.rd_ok  = rd_ok;
    assign o_res.status = status;
    assign o_count      = n_count;

    `PIE_ASSERT(a_count_bound, r_count <= CAP_CNT, "word count above capacity")
    `PIE_ASSERT(a_count_hold, i_rst_n && !i_accept |=> $stable(r_count), "count moved while idle")
    `PIE_ASSERT(a_reject_hold, i_accept && (status != ST_OK) |=> $stable(r_count),
                "rejected request changed the count")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the positional insert/erase array. A shadow copy
// of the list predicts every response word; random traffic in growing,
// shrinking, mixed and noisy phases drives the list between empty and full
// while both handshakes idle and stall at random.
// ============================================================================

module tb_top;

    import pie_pkg::*;

    localparam int CAP         = 64;
    localparam int COUNT_W     = $clog2(CAP + 1);
    localparam int N_RANDOM    = 1350;
    localparam int CYCLE_LIMIT = 1000000;

    // Request code that the block must ignore.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef enum {MODE_GROW, MODE_MIX, MODE_SHRINK, MODE_NOISE} t_stim_mode;

    // One expected response word.
    typedef struct {
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        t_status                  status;
    } t_rsp_word;

    // ------------------------------------------------------------------------
    // Shadow list: applies each accepted request to its own copy of the
    // contents and count, queues the response word that request must give,
    // and checks response words against that queue in order.
    // ------------------------------------------------------------------------
    class list_shadow;
        logic signed [WORD_W-1:0] cells[CAP];
        int                       held;
        t_rsp_word                awaited[$];
        int                       failures;
        int                       checked;
        int                       status_seen[3];
        int                       peak;

        function new();
            held     = 0;
            failures = 0;
            checked  = 0;
            peak     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Moves words at pos and above up one place and puts word at pos.
        function void open_gap(int pos, logic signed [WORD_W-1:0] word);
            for (int i = held; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = word;
            held++;
        endfunction

        function void apply_request(logic [2:0] code, logic [INDEX_W-1:0] idx,
                                    logic signed [WORD_W-1:0] val);
            t_rsp_word exp;
            logic      full;
            exp.read_value = '0;
            exp.status     = ST_OK;
            full           = (held >= CAP);
            case (code)
                REQ_READ: begin
                    if (idx < held) exp.read_value = cells[idx];
                    else exp.status = ST_RANGE;
                end
                REQ_WRITE: begin
                    if (idx < held) cells[idx] = val;
                    else exp.status = ST_RANGE;
                end
                REQ_APPEND: begin
                    if (full) exp.status = ST_FULL;
                    else open_gap(held, val);
                end
                REQ_PREPEND: begin
                    if (full) exp.status = ST_FULL;
                    else open_gap(0, val);
                end
                REQ_INSERT: begin
                    // A bad position wins over a full list.
                    if (idx > held) exp.status = ST_RANGE;
                    else if (full) exp.status = ST_FULL;
                    else open_gap(idx, val);
                end
                REQ_ERASE: begin
                    if (idx < held) begin
                        for (int i = idx; i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                    end else begin
                        exp.status = ST_RANGE;
                    end
                end
                REQ_CLEAR: held = 0;
                default: ;
            endcase
            exp.count    = COUNT_W'(held);
            exp.is_empty = (held == 0);
            if (held > peak) peak = held;
            status_seen[exp.status]++;
            awaited.insert(awaited.size(), exp);
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, exp_v,
                     act_v);
            failures++;
        endfunction

        function void check_response(logic signed [WORD_W-1:0] rd, logic [COUNT_W-1:0] cnt,
                                     logic empty, logic [1:0] st);
            t_rsp_word exp;
            if (awaited.size() == 0) begin
                $display("%0t: response word with none expected (count %0d, status %0d)",
                         $time, cnt, st);
                failures++;
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (rd !== exp.read_value) report("read_value", exp.read_value, rd);
            if (cnt !== exp.count) report("count", exp.count, cnt);
            if (empty !== exp.is_empty) report("is_empty", exp.is_empty, empty);
            if (st !== exp.status) report("status", exp.status, st);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    int         cycle_count;
    list_shadow shadow;

    pie_req_if                      req_if ();
    pie_rsp_if #(.CAPACITY(CAP))    rsp_if ();

    positional_insert_erase_array #(
        .CAPACITY   (CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Presents one request word after gap idle cycles and holds it until the
    // block takes it. The shadow list is updated here, at the accepting edge,
    // so the next random choice always sees the count after this request.
    task automatic send_word(input logic [2:0] code, input logic [INDEX_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid    <= 1'b1;
        req_if.req_type <= code;
        req_if.index    <= idx;
        req_if.value    <= val;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.apply_request(code, idx, val);
    endtask

    // Stops sending and waits until every expected response has come back.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
    endtask

    // Builds one random request. Most requests are well formed against the
    // current list so that the list really fills up and empties again; a
    // share of positions is drawn from the whole index range.
    function automatic void pick_request(t_stim_mode mode, output logic [2:0] code,
                                         output logic [INDEX_W-1:0] idx,
                                         output logic signed [WORD_W-1:0] val);
        int          r;
        int          hi;
        t_req_type   grow_ops[3];
        logic signed [WORD_W-1:0] extremes[5];
        grow_ops = '{REQ_APPEND, REQ_PREPEND, REQ_INSERT};
        extremes = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1};
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 60) code = grow_ops[$urandom_range(0, 2)];
                else if (r < 75) code = REQ_READ;
                else if (r < 87) code = REQ_WRITE;
                else code = REQ_ERASE;
            end
            MODE_SHRINK: begin
                if (r < 50) code = REQ_ERASE;
                else if (r < 62) code = grow_ops[$urandom_range(0, 2)];
                else if (r < 80) code = REQ_READ;
                else if (r < 97) code = REQ_WRITE;
                else code = REQ_CLEAR;
            end
            MODE_MIX: begin
                if (r < 35) code = grow_ops[$urandom_range(0, 2)];
                else if (r < 55) code = REQ_ERASE;
                else if (r < 75) code = REQ_READ;
                else if (r < 93) code = REQ_WRITE;
                else if (r < 97) code = REQ_CLEAR;
                else code = REQ_UNUSED;
            end
            default: code = 3'($urandom_range(0, 7));
        endcase

        if (mode == MODE_NOISE || $urandom_range(0, 99) < 12) begin
            idx = INDEX_W'($urandom_range(0, 63));
        end else if (code == REQ_INSERT) begin
            hi  = (shadow.held > 63) ? 63 : shadow.held;
            idx = INDEX_W'($urandom_range(0, hi));
        end else begin
            idx = (shadow.held == 0) ? '0 : INDEX_W'($urandom_range(0, shadow.held - 1));
        end

        if ($urandom_range(0, 9) == 0) val = extremes[$urandom_range(0, 4)];
        else val = $urandom;
    endfunction

    // Response side: the ready line idles in random stretches.
    initial begin
        int stall;
        int run;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (run - 1) @(negedge i_clk);
        end
    end

    // Response words are sampled at the rising edge, where inputs are stable.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            shadow.check_response(rsp_if.read_value, rsp_if.count, rsp_if.is_empty,
                                  rsp_if.status);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d responses outstanding", $time,
                     shadow.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Main sequence: reset, directed corner cases, then random phases.
    initial begin
        t_stim_mode               mode;
        logic [2:0]               code;
        logic [INDEX_W-1:0]       idx;
        logic signed [WORD_W-1:0] val;
        int                       sent;
        int                       seg;
        int                       len;
        bit                       burst;

        shadow           = new();
        cycle_count      = 0;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = '0;
        req_if.index     = '0;
        req_if.value     = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list: clear is fine, every positional request is out of
        // range, and the unused code changes nothing.
        send_word(REQ_CLEAR,   6'd0,  32'sd0, pick_gap());
        send_word(REQ_READ,    6'd0,  32'sd0, pick_gap());
        send_word(REQ_ERASE,   6'd0,  32'sd0, pick_gap());
        send_word(REQ_WRITE,   6'd0,  32'sd5, pick_gap());
        send_word(REQ_UNUSED,  6'd63, 32'sh7fffffff, pick_gap());
        // Build [-1, min, max, 0] with both extreme words.
        send_word(REQ_APPEND,  6'd0,  32'sh7fffffff, pick_gap());
        send_word(REQ_PREPEND, 6'd63, 32'sh80000000, pick_gap());
        send_word(REQ_INSERT,  6'd2,  32'sd0, pick_gap());    // at the end
        send_word(REQ_INSERT,  6'd0,  -32'sd1, pick_gap());   // at the front
        send_word(REQ_INSERT,  6'd5,  32'sd9, pick_gap());    // past the end
        send_word(REQ_INSERT,  6'd63, 32'sd9, pick_gap());
        for (int i = 0; i < 4; i++) send_word(REQ_READ, INDEX_W'(i), 32'sd0, pick_gap());
        send_word(REQ_WRITE,   6'd3,  32'sh55555555, pick_gap());
        send_word(REQ_READ,    6'd3,  32'sd0, pick_gap());
        send_word(REQ_READ,    6'd4,  32'sd0, pick_gap());    // index equal to count
        send_word(REQ_ERASE,   6'd0,  32'sd0, pick_gap());
        send_word(REQ_ERASE,   6'd2,  32'sd0, pick_gap());    // last word
        send_word(REQ_READ,    6'd63, 32'sd0, pick_gap());
        send_word(REQ_ERASE,   6'd63, 32'sd0, pick_gap());
        send_word(REQ_CLEAR,   6'd0,  32'sd0, pick_gap());
        send_word(REQ_READ,    6'd0,  32'sd0, pick_gap());
        drain();

        // Random phases. Every phase ends with the sender holding off until
        // all responses are back; some phases run with no sender gaps.
        sent = 0;
        seg  = 0;
        while (sent < N_RANDOM) begin
            case (seg % 3)
                0: mode = MODE_GROW;
                1: mode = ($urandom_range(0, 3) == 0) ? MODE_NOISE : MODE_MIX;
                default: mode = MODE_SHRINK;
            endcase
            len   = (mode == MODE_GROW) ? $urandom_range(120, 220) :
                    (mode == MODE_NOISE) ? $urandom_range(30, 60) : $urandom_range(60, 150);
            burst = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < len && sent < N_RANDOM; k++) begin
                pick_request(mode, code, idx, val);
                send_word(code, idx, val, burst ? 0 : pick_gap());
                if (code != REQ_UNUSED) sent++;
            end
            drain();
            seg++;
        end

        repeat (4) @(posedge i_clk);
        $display("Checked %0d response words over %0d random phases; list peaked at %0d words.",
                 shadow.checked, seg, shadow.peak);
        $display("Status mix: %0d ok, %0d rejected as full, %0d out of range.",
                 shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
                 shadow.status_seen[ST_RANGE]);
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: positional_insert_erase_array.f
+incdir+rtl
rtl/pie_pkg.sv
rtl/pie_req_if.sv
rtl/pie_rsp_if.sv
rtl/pie_cell.sv
rtl/pie_ctrl.sv
rtl/positional_insert_erase_array.sv
tb/tb_top.sv
